// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/iomlp_pkg.sv =====
`timescale 1ns / 1ps
package iomlp_pkg;
    localparam int NumFeatures  = 12;
    localparam int HiddenOne    = 128;
    localparam int HiddenTwo    = 16;
    localparam int NumDevices   = 2;
    localparam int TableWords   = 2048;
    localparam int ShiftOne     = 30;
    localparam int DevW         = (NumDevices > 1) ? $clog2(NumDevices) : 1;
    localparam int WAddrW       = DevW + 3 + 11;
    localparam int WDepth       = NumDevices * 8 * TableWords;
    localparam int H1W          = $clog2(HiddenOne + 1);
    localparam int H2W          = $clog2(HiddenTwo + 1);
    localparam int FW           = 4;

    typedef enum logic [1:0] {
        CMD_INFER = 2'd0,
        CMD_HIST  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [2:0] SEL_MIN   = 3'd0;
    localparam logic [2:0] SEL_SCALE = 3'd1;
    localparam logic [2:0] SEL_W1    = 3'd2;
    localparam logic [2:0] SEL_B1    = 3'd3;
    localparam logic [2:0] SEL_W2    = 3'd4;
    localparam logic [2:0] SEL_B2    = 3'd5;
    localparam logic [2:0] SEL_WOUT  = 3'd6;
    localparam logic [2:0] SEL_BOUT  = 3'd7;
endpackage

// ===== rtl/core/io_admission_mlp_inference_core.sv =====
`timescale 1ns / 1ps
// Integer MLP admission filter for I/O requests.
// Input channel: i_valid/o_stall with one port per item field. Command
// "infer" yields one transfer on the output channel (o_valid/i_stall,
// o_reject); "history push", "weight load" and the unused code yield none.
// Items are handled one at a time. A load or history push leaves o_stall low.
// An inference walks the weight memory through one shared multiply-add
// unit: each weight word costs one memory read. Each 64 x 32
// product is formed as two registered 32 x 32 partial products that are
// combined in the accumulate stage. The phases are normalisation (12 min
// and 12 scale reads), hidden layer one (HiddenOne x (12 + 1) words),
// hidden layer two (HiddenTwo x (HiddenOne + 1) words) and the output row
// (HiddenTwo + 1 words), 3769 reads at the default sizes, and each phase
// ends in a drain state that waits for the read and product stages to empty;
// the decision follows the last drain. The single weight read port paces the walk.
// Reset (synchronous, active low) clears the history and the sequencer and
// holds o_stall high; the weight memory holds whatever was written.
// The result sits in an output register; while i_stall is high it holds
// and the block takes no new item until that transfer completes.
module io_admission_mlp_inference_core import iomlp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_io_type,
    input  logic [31:0] i_io_size,
    input  logic        i_device,
    input  logic [15:0] i_cur_queue_len,
    input  logic [15:0] i_done_queue_len,
    input  logic [31:0] i_done_latency,
    input  logic [31:0] i_done_throughput,
    input  logic [2:0]  i_table_sel,
    input  logic [10:0] i_table_addr,
    input  logic signed [31:0] i_table_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_reject
);
    // Sequencer states. Each working state issues one weight read per cycle.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NMIN  = 8'b0000_0010,
        S_NSCL  = 8'b0000_0100,
        S_L1    = 8'b0000_1000,
        S_L2    = 8'b0001_0000,
        S_LO    = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    // Operation tags travelling alongside a memory read.
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_MIN  = 3'd1,
        OP_SCL  = 3'd2,
        OP_MAC1 = 3'd3,
        OP_MAC2 = 3'd4,
        OP_BIAS = 3'd5,
        OP_MACO = 3'd6,
        OP_BOUT = 3'd7
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] idx;  // feature / neuron index used by the operation
        logic [7:0] dst;  // destination neuron for bias write-back
        logic [1:0] lay;  // layer for bias: 1, 2
    } t_tag;

    logic [31:0] r_wmem [WDepth];
    logic [31:0] r_rdata;
    logic [63:0] r_h1mem [HiddenOne];
    logic [63:0] r_h1q;
    logic [63:0] r_feat [NumFeatures];
    logic [63:0] r_h2 [HiddenTwo];

    logic [15:0] r_hq [3];
    logic [31:0] r_hl [3];
    logic [31:0] r_ht [3];
    logic [1:0]  r_hcnt;

    t_state      r_state;
    logic [DevW-1:0] r_dev;
    logic [7:0]  r_j;
    logic [7:0]  r_i;
    t_tag        r_tag1;   // tag of the read in flight
    t_tag        r_tag2;   // tag aligned with the partial product registers
    logic [63:0] r_plo;
    logic [31:0] r_phi;
    logic [63:0] r_acc;
    logic        r_valid;
    logic        r_reject;
    logic [2:0]  r_drain;

    logic        acc_in;
    logic        rd_en;
    logic [WAddrW-1:0] rd_addr;
    t_tag        n_tag;
    logic [63:0] b_sx;
    logic [63:0] opa;
    logic [63:0] plo_in;
    logic [31:0] phi_in;
    logic [63:0] prod;
    logic [63:0] sum;

    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign acc_in   = i_valid && !o_stall;
    assign o_valid  = r_valid;
    assign o_reject = r_reject;

    function automatic logic [WAddrW-1:0] waddr(logic [DevW-1:0] d, logic [2:0] s,
                                                 logic [10:0] a);
        waddr = {d, s, a};
    endfunction

    // Read issue: one word per cycle as the sequencer walks the tables.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        n_tag   = '{op: OP_NONE, idx: r_i, dst: r_j, lay: 2'd0};
        case (r_state)
            S_NMIN: begin
                rd_en = 1'b1;
                rd_addr = waddr(r_dev, SEL_MIN, 11'(r_i));
                n_tag.op = OP_MIN;
            end
            S_NSCL: begin
                rd_en = 1'b1;
                rd_addr = waddr(r_dev, SEL_SCALE, 11'(r_i));
                n_tag.op = OP_SCL;
            end
            S_L1: begin
                rd_en = 1'b1;
                if (r_i == 8'(NumFeatures)) begin
                    rd_addr = waddr(r_dev, SEL_B1, 11'(r_j));
                    n_tag.op = OP_BIAS;
                    n_tag.lay = 2'd1;
                end else begin
                    rd_addr = waddr(r_dev, SEL_W1,
                                    11'(32'(r_j) * NumFeatures + 32'(r_i)));
                    n_tag.op = OP_MAC1;
                end
            end
            S_L2: begin
                rd_en = 1'b1;
                if (32'(r_i) == HiddenOne) begin
                    rd_addr = waddr(r_dev, SEL_B2, 11'(r_j));
                    n_tag.op = OP_BIAS;
                    n_tag.lay = 2'd2;
                end else begin
                    rd_addr = waddr(r_dev, SEL_W2, 11'(32'(r_j) * HiddenOne + 32'(r_i)));
                    n_tag.op = OP_MAC2;
                end
            end
            S_LO: begin
                rd_en = 1'b1;
                if (32'(r_i) == HiddenTwo) begin
                    rd_addr = waddr(r_dev, SEL_BOUT, 11'd0);
                    n_tag.op = OP_BOUT;
                end else begin
                    rd_addr = waddr(r_dev, SEL_WOUT, 11'(r_i));
                    n_tag.op = OP_MACO;
                end
            end
            default: ;
        endcase
    end

    // Weight memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (acc_in && t_cmd'(i_cmd) == CMD_LOAD) begin
            r_wmem[waddr(DevW'(i_device), i_table_sel, i_table_addr)] <= i_table_value;
        end
        if (rd_en) begin
            r_rdata <= r_wmem[rd_addr];
        end
    end

    // Hidden layer one is a memory read by index in step with the weight read.
    always_ff @(posedge i_clk) begin
        if (r_state == S_L2 && 32'(r_i) < HiddenOne) begin
            r_h1q <= r_h1mem[r_i[H1W-2:0]];
        end
    end

    // Stage 2: partial products of the operand and the word just read.
    // With the word w sign-extended, a * w keeps its low 64 bits as
    // a_lo * w + ((a_hi * w - (w negative ? a_lo : 0)) << 32). Operations
    // without a multiply use an operand of one, passing the word through.
    assign b_sx = {{32{r_rdata[31]}}, r_rdata};
    always_comb begin
        opa = 64'd1;
        case (r_tag1.op)
            OP_MAC1, OP_SCL: opa = r_feat[r_tag1.idx[FW-1:0]];
            OP_MAC2: opa = r_h1q;
            OP_MACO: opa = r_h2[r_tag1.idx[H2W-2:0]];
            default: opa = 64'd1;
        endcase
        plo_in = 64'(opa[31:0]) * 64'(r_rdata);
        phi_in = 32'(opa[63:32] * r_rdata) - (r_rdata[31] ? opa[31:0] : 32'd0);
    end

    // Stage 3: product assembly, accumulation and write-back.
    assign prod = r_plo + {r_phi, 32'd0};
    always_comb begin
        sum = r_acc;
        case (r_tag2.op)
            OP_MAC1: sum = r_acc + {{ShiftOne{prod[63]}}, prod[63:ShiftOne]};
            OP_MAC2, OP_MACO: sum = r_acc + prod;
            OP_BIAS, OP_BOUT: sum = r_acc + prod;
            default: sum = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_plo <= plo_in;
        r_phi <= phi_in;
        case (r_tag2.op)
            OP_MAC1, OP_MAC2, OP_MACO: r_acc <= sum;
            OP_BIAS: begin
                r_acc <= '0;
                if (r_tag2.lay == 2'd1) begin
                    r_h1mem[r_tag2.dst[H1W-2:0]] <= sum[63] ? '0 : sum;
                end else begin
                    r_h2[r_tag2.dst[H2W-2:0]] <= sum[63] ? '0 : sum;
                end
            end
            OP_BOUT: r_acc <= sum;
            default: ;
        endcase
        // Normalisation runs on the feature registers: the min is taken off
        // as its word arrives, and the scaled value is written back once the
        // product has been assembled. The two always touch different features.
        if (r_tag1.op == OP_MIN) begin
            r_feat[r_tag1.idx[FW-1:0]] <= r_feat[r_tag1.idx[FW-1:0]] - b_sx;
        end
        if (r_tag2.op == OP_SCL) begin
            r_feat[r_tag2.idx[FW-1:0]] <= prod;
        end
        if (acc_in && t_cmd'(i_cmd) == CMD_INFER) begin
            r_acc <= '0;
            r_feat[0]  <= 64'(i_io_type);
            r_feat[1]  <= 64'(i_io_size);
            r_feat[2]  <= 64'(i_cur_queue_len);
            for (int k = 0; k < 3; k++) begin
                r_feat[3 + k] <= (r_hcnt > 2'(k)) ? 64'(r_hq[k]) : '0;
                r_feat[6 + k] <= (r_hcnt > 2'(k)) ? 64'(r_hl[k]) : '0;
                r_feat[9 + k] <= (r_hcnt > 2'(k)) ? 64'(r_ht[k]) : '0;
            end
        end
    end

    // History, tags, sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (acc_in && t_cmd'(i_cmd) == CMD_HIST) begin
            r_hq[2] <= r_hq[1];
            r_hl[2] <= r_hl[1];
            r_ht[2] <= r_ht[1];
            r_hq[1] <= r_hq[0];
            r_hl[1] <= r_hl[0];
            r_ht[1] <= r_ht[0];
            r_hq[0] <= i_done_queue_len;
            r_hl[0] <= i_done_latency;
            r_ht[0] <= i_done_throughput;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hcnt  <= '0;
            r_valid <= 1'b0;
            r_tag1  <= '{op: OP_NONE, idx: '0, dst: '0, lay: '0};
            r_tag2  <= '{op: OP_NONE, idx: '0, dst: '0, lay: '0};
            r_i     <= '0;
            r_j     <= '0;
            r_drain <= '0;
        end else begin
            r_tag1 <= n_tag;
            r_tag2 <= r_tag1;
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (acc_in && t_cmd'(i_cmd) == CMD_HIST && r_hcnt != 2'd3) begin
                r_hcnt <= r_hcnt + 2'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in && t_cmd'(i_cmd) == CMD_INFER) begin
                        r_dev   <= DevW'(i_device);
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_NMIN;
                    end
                end
                S_NMIN: begin
                    r_state <= S_NSCL;
                end
                S_NSCL: begin
                    // Min of the next feature is read once this scale lands.
                    if (32'(r_i) == NumFeatures - 1) begin
                        r_i <= '0;
                        r_state <= S_DRAIN;
                        r_drain <= 3'd1;
                    end else begin
                        r_i <= r_i + 8'd1;
                        r_state <= S_NMIN;
                    end
                end
                S_L1: begin
                    if (r_i == 8'(NumFeatures)) begin
                        r_i <= '0;
                        if (32'(r_j) == HiddenOne - 1) begin
                            r_j <= '0;
                            r_state <= S_DRAIN;
                            r_drain <= 3'd2;
                        end else begin
                            r_j <= r_j + 8'd1;
                        end
                    end else begin
                        r_i <= r_i + 8'd1;
                    end
                end
                S_L2: begin
                    if (32'(r_i) == HiddenOne) begin
                        r_i <= '0;
                        if (32'(r_j) == HiddenTwo - 1) begin
                            r_j <= '0;
                            r_state <= S_DRAIN;
                            r_drain <= 3'd3;
                        end else begin
                            r_j <= r_j + 8'd1;
                        end
                    end else begin
                        r_i <= r_i + 8'd1;
                    end
                end
                S_LO: begin
                    if (32'(r_i) == HiddenTwo) begin
                        r_i <= '0;
                        r_state <= S_DRAIN;
                        r_drain <= 3'd4;
                    end else begin
                        r_i <= r_i + 8'd1;
                    end
                end
                S_DRAIN: begin
                    // Wait until the read and product stages are empty.
                    if (r_tag1.op == OP_NONE && r_tag2.op == OP_NONE) begin
                        case (r_drain)
                            3'd1: r_state <= S_L1;
                            3'd2: r_state <= S_L2;
                            3'd3: r_state <= S_LO;
                            default: begin
                                r_state  <= S_OUT;
                                r_reject <= ~r_acc[63];
                                r_valid  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/iomlp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iomlp_checker import iomlp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic [1:0] i_cmd,
    input logic o_valid,
    input logic i_stall,
    input logic o_reject
);
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
              o_valid && $stable(o_reject), "result dropped")
    `CHK_NEXT(a_start, i_clk, i_rst_n, i_valid && !o_stall && i_cmd == CMD_INFER,
              o_stall, "infer did not start")
    `CHK_NEXT(a_other, i_clk, i_rst_n, i_valid && !o_stall && i_cmd != CMD_INFER,
              !o_stall, "non-infer blocked")
    `CHK_IMPLY(a_busy, i_clk, i_rst_n, o_valid, o_stall, "result while idle")
endmodule

bind io_admission_mlp_inference_core iomlp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_cmd(i_cmd), .o_valid(o_valid), .i_stall(i_stall), .o_reject(o_reject)
);

// ===== tb/tb_io_admission_mlp_inference_core.sv =====
`timescale 1ns / 1ps
module tb_io_admission_mlp_inference_core;
    import iomlp_pkg::*;

    // One request as it is offered on the input channel. The drain flag makes
    // the sender wait until every outstanding decision has been received.
    typedef struct {
        t_cmd        cmd;
        bit          io_type;
        bit [31:0]   io_size;
        bit          device;
        bit [15:0]   cur_q;
        bit [15:0]   done_q;
        bit [31:0]   done_lat;
        bit [31:0]   done_tp;
        bit [2:0]    sel;
        bit [10:0]   addr;
        bit [31:0]   value;
        bit          drain;
    } t_io_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic        i_io_type;
    logic [31:0] i_io_size;
    logic        i_device;
    logic [15:0] i_cur_queue_len;
    logic [15:0] i_done_queue_len;
    logic [31:0] i_done_latency;
    logic [31:0] i_done_throughput;
    logic [2:0]  i_table_sel;
    logic [10:0] i_table_addr;
    logic signed [31:0] i_table_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_reject;

    io_admission_mlp_inference_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_io_type         (i_io_type),
        .i_io_size         (i_io_size),
        .i_device          (i_device),
        .i_cur_queue_len   (i_cur_queue_len),
        .i_done_queue_len  (i_done_queue_len),
        .i_done_latency    (i_done_latency),
        .i_done_throughput (i_done_throughput),
        .i_table_sel       (i_table_sel),
        .i_table_addr      (i_table_addr),
        .i_table_value     (i_table_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_reject          (o_reject)
    );

    // Shadow copy of the block's state, advanced as each transfer is accepted.
    bit [31:0]   wmem [NumDevices][8][TableWords];
    bit [15:0]   hist_q [3];
    bit [31:0]   hist_lat [3];
    bit [31:0]   hist_tp [3];
    int          hist_fill;

    t_io_item    item_q [$];
    bit          reject_q [$];
    t_io_item    cur_item;
    logic        took;
    int          gap_left;
    int          stall_left;
    int          hold_left;
    bit          held;
    int          decisions_seen;
    int          mismatches;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Most gaps are short; roughly one in ten is a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Weight word sign-extended to the 64-bit datapath width.
    function automatic longint unsigned wv(bit dev, logic [2:0] sel, int idx);
        return longint'($signed(wmem[dev][sel][idx & (TableWords - 1)]));
    endfunction

    // Full forward pass of the network for one request, wrapping at 64 bits.
    function automatic bit reject_decision(bit dev, bit typ, bit [31:0] size,
                                           bit [15:0] qlen);
        longint unsigned feat [NumFeatures];
        longint unsigned norm [NumFeatures];
        longint unsigned h1 [HiddenOne];
        longint unsigned h2 [HiddenTwo];
        longint unsigned acc;
        longint          sp;
        foreach (feat[i]) feat[i] = 0;
        feat[0] = 64'(typ);
        feat[1] = 64'(size);
        feat[2] = 64'(qlen);
        for (int i = 0; i < 3; i++) begin
            if (hist_fill > i) begin
                feat[3 + i] = 64'(hist_q[i]);
                feat[6 + i] = 64'(hist_lat[i]);
                feat[9 + i] = 64'(hist_tp[i]);
            end
        end
        for (int i = 0; i < NumFeatures; i++)
            norm[i] = (feat[i] - wv(dev, SEL_MIN, i)) * wv(dev, SEL_SCALE, i);
        for (int j = 0; j < HiddenOne; j++) begin
            acc = 0;
            // The shift is done on a signed variable so that it is arithmetic.
            for (int i = 0; i < NumFeatures; i++) begin
                sp = longint'(norm[i] * wv(dev, SEL_W1, j * NumFeatures + i));
                sp = sp >>> ShiftOne;
                acc += $unsigned(sp);
            end
            acc += wv(dev, SEL_B1, j);
            h1[j] = acc[63] ? 64'd0 : acc;
        end
        for (int j = 0; j < HiddenTwo; j++) begin
            acc = 0;
            for (int i = 0; i < HiddenOne; i++)
                acc += h1[i] * wv(dev, SEL_W2, j * HiddenOne + i);
            acc += wv(dev, SEL_B2, j);
            h2[j] = acc[63] ? 64'd0 : acc;
        end
        acc = 0;
        for (int i = 0; i < HiddenTwo; i++)
            acc += h2[i] * wv(dev, SEL_WOUT, i);
        acc += wv(dev, SEL_BOUT, 0);
        return !acc[63];
    endfunction

    // Advances the shadow state by one accepted transfer.
    task automatic absorb_item(t_io_item it);
        case (it.cmd)
            CMD_INFER: reject_q.push_back(reject_decision(it.device, it.io_type,
                                                          it.io_size, it.cur_q));
            CMD_HIST: begin
                for (int k = 2; k > 0; k--) begin
                    hist_q[k]   = hist_q[k - 1];
                    hist_lat[k] = hist_lat[k - 1];
                    hist_tp[k]  = hist_tp[k - 1];
                end
                hist_q[0]   = it.done_q;
                hist_lat[0] = it.done_lat;
                hist_tp[0]  = it.done_tp;
                if (hist_fill < 3) hist_fill++;
            end
            CMD_LOAD: wmem[it.device][it.sel][it.addr] = it.value;
            default: ;
        endcase
    endtask

    function automatic t_io_item any_item(t_cmd c);
        t_io_item it;
        it.cmd      = c;
        it.io_type  = 1'($urandom_range(0, 1));
        it.io_size  = $urandom;
        it.device   = 1'($urandom_range(0, 1));
        it.cur_q    = 16'($urandom);
        it.done_q   = 16'($urandom);
        it.done_lat = $urandom;
        it.done_tp  = $urandom;
        it.sel      = 3'($urandom);
        it.addr     = 11'($urandom);
        it.value    = $urandom;
        it.drain    = 1'b0;
        return it;
    endfunction

    function automatic t_io_item load_item(bit dev, logic [2:0] sel, int idx,
                                           bit [31:0] val);
        t_io_item it;
        it        = any_item(CMD_LOAD);
        it.device = dev;
        it.sel    = sel;
        it.addr   = 11'(idx);
        it.value  = val;
        return it;
    endfunction

    // Accepted transfers are folded into the shadow state at the clock edge.
    always @(posedge i_clk) begin
        took <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) absorb_item(cur_item);
    end

    // Sender: presents queued items at the falling edge and holds a stalled one.
    always @(negedge i_clk) begin
        t_io_item  nxt;
        logic      nxt_valid;
        if (i_rst_n) begin
            nxt_valid = i_valid && !took;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_q.size() > 0 &&
                             (!item_q[0].drain || reject_q.size() == 0)) begin
                    nxt = item_q.pop_front();
                    cur_item          <= nxt;
                    i_cmd             <= nxt.cmd;
                    i_io_type         <= nxt.io_type;
                    i_io_size         <= nxt.io_size;
                    i_device          <= nxt.device;
                    i_cur_queue_len   <= nxt.cur_q;
                    i_done_queue_len  <= nxt.done_q;
                    i_done_latency    <= nxt.done_lat;
                    i_done_throughput <= nxt.done_tp;
                    i_table_sel       <= nxt.sel;
                    i_table_addr      <= nxt.addr;
                    i_table_value     <= nxt.value;
                    nxt_valid = 1'b1;
                    gap_left  = rand_gap();
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // Receiver stall pattern. After twenty decisions it holds off for a long
    // stretch while the sender keeps offering, so the block backs up.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (decisions_seen == 20 && !held) begin
                held      = 1'b1;
                hold_left = 15000;
                i_stall   <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = rand_gap();
                i_stall <= (stall_left > 0);
            end
        end
    end

    // Monitor: each decision transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            decisions_seen <= decisions_seen + 1;
            if (reject_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: decision %0b arrived with none outstanding", o_reject);
            end else begin
                want = reject_q.pop_front();
                if (o_reject !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: reject expected %0b got %0b", want, o_reject);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int        table_len [8];
        t_io_item  it;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = CMD_NONE;
        i_io_type = '0; i_io_size = '0; i_device = '0; i_cur_queue_len = '0;
        i_done_queue_len = '0; i_done_latency = '0; i_done_throughput = '0;
        i_table_sel = '0; i_table_addr = '0; i_table_value = '0;
        cur_item = any_item(CMD_NONE);
        took = 0; gap_left = 0; stall_left = 0; hold_left = 0; held = 0;
        decisions_seen = 0; mismatches = 0; hist_fill = 0;
        foreach (hist_q[k]) begin
            hist_q[k] = 0; hist_lat[k] = 0; hist_tp[k] = 0;
        end
        table_len = '{NumFeatures, NumFeatures, HiddenOne * NumFeatures, HiddenOne,
                      HiddenTwo * HiddenOne, HiddenTwo, HiddenTwo, 1};

        // Every weight an inference reads is written before the first one runs,
        // for both devices, since unwritten words have no defined value.
        for (int d = 0; d < NumDevices; d++)
            for (int s = 0; s < 8; s++)
                for (int k = 0; k < table_len[s]; k++)
                    item_q.push_back(load_item(1'(d), 3'(s), k, $urandom));
        // Extreme words, including the top index of a table.
        item_q.push_back(load_item(1'b0, SEL_W1, TableWords - 1, 32'h8000_0000));
        item_q.push_back(load_item(1'b1, SEL_W2, TableWords - 1, 32'h7fff_ffff));

        // Directed: an empty history, field extremes, history saturation,
        // the unused command and both output biases at their extremes.
        it = any_item(CMD_INFER); it.io_size = 0; it.cur_q = 0; it.io_type = 0;
        it.device = 0; item_q.push_back(it);
        it = any_item(CMD_INFER); it.io_size = '1; it.cur_q = '1; it.io_type = 1;
        it.device = 1; item_q.push_back(it);
        for (int k = 0; k < 4; k++) begin
            it = any_item(CMD_HIST);
            it.done_q   = k[0] ? 16'hffff : 16'h0;
            it.done_lat = k[0] ? 32'hffff_ffff : 32'h0;
            it.done_tp  = k[1] ? 32'hffff_ffff : 32'h0;
            item_q.push_back(it);
            if (k == 0) item_q.push_back(any_item(CMD_INFER));
        end
        item_q.push_back(any_item(CMD_NONE));
        item_q.push_back(load_item(1'b0, SEL_BOUT, 0, 32'h7fff_ffff));
        item_q.push_back(load_item(1'b1, SEL_BOUT, 0, 32'h8000_0000));
        it = any_item(CMD_INFER); it.device = 0; item_q.push_back(it);
        it = any_item(CMD_INFER); it.device = 1; item_q.push_back(it);
        item_q.push_back(load_item(1'b0, SEL_BOUT, 0, $urandom));
        item_q.push_back(load_item(1'b1, SEL_BOUT, 0, $urandom));
        item_q.push_back(any_item(CMD_INFER));

        // Random traffic; one item partway through waits for a full drain.
        for (int n = 0; n < 140; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                it = any_item(CMD_INFER);
            end else if (r < 70) begin
                it = any_item(CMD_HIST);
            end else if (r < 95) begin
                it = any_item(CMD_LOAD);
                if ($urandom_range(0, 1)) begin
                    it.sel  = 3'($urandom_range(0, 7));
                    it.addr = 11'($urandom_range(0, table_len[it.sel] - 1));
                end
            end else begin
                it = any_item(CMD_NONE);
            end
            it.drain = (n == 70);
            item_q.push_back(it);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Checked at rising edges, where the driven inputs have settled.
        do @(posedge i_clk);
        while (!(item_q.size() == 0 && !i_valid && reject_q.size() == 0));
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && reject_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Safety net: far beyond the slowest legal run.
    initial begin
        #(12 * 3_000_000);
        $display("ERROR: timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
